>>> rtl/clg_pkg.sv
// clg_pkg: shared widths, constants, register indexes and sequencer states
// for the compressor / limiter / gate block. No dependencies.
package clg_pkg;

  localparam int SAMPLE_W   = 24;
  localparam int COEF_W     = 24;
  localparam int THR_W      = 27;
  localparam int GTHR_W     = 25;
  localparam int CFG_W      = 27;
  localparam int IDX_W      = 3;
  localparam int MUL_A_W    = 27;
  localparam int MUL_B_W    = 24;
  localparam int PROD_W     = MUL_A_W + MUL_B_W;
  localparam int DEN_W      = 28;
  localparam int DIVIDEND_W = 51;
  localparam int QUOT_W     = 24;

  localparam logic [COEF_W-1:0]     ONE_Q23   = 24'h800000;
  localparam logic [SAMPLE_W-1:0]   MAX_POS   = 24'h7FFFFF;
  localparam logic [SAMPLE_W-1:0]   MIN_NEG   = 24'h800000;
  localparam logic [DIVIDEND_W-1:0] LIMIT_ONE = 51'h80000000000;

  localparam logic [IDX_W-1:0] REG_COMP_THRESHOLD     = 3'd0;
  localparam logic [IDX_W-1:0] REG_RATIO_COEFF        = 3'd1;
  localparam logic [IDX_W-1:0] REG_MAKEUP_GAIN        = 3'd2;
  localparam logic [IDX_W-1:0] REG_ATTACK_COEFF       = 3'd3;
  localparam logic [IDX_W-1:0] REG_RELEASE_COEFF      = 3'd4;
  localparam logic [IDX_W-1:0] REG_GATE_THRESHOLD     = 3'd5;
  localparam logic [IDX_W-1:0] REG_GATE_ATTACK_COEFF  = 3'd6;
  localparam logic [IDX_W-1:0] REG_GATE_RELEASE_COEFF = 3'd7;

  typedef enum logic [4:0] {
    S_IDLE,
    S_PEAK,
    S_LE_REL,
    S_HP_REL,
    S_ATK,
    S_COMP,
    S_COMP_DEN,
    S_COMP_DIV_START,
    S_DIV_COMP,
    S_LIM,
    S_LIM_CHK,
    S_DIV_LIM,
    S_GATE,
    S_GATE_UPD,
    S_FIN,
    S_FIN_GAIN,
    S_OUT_A,
    S_OUT_B,
    S_PUSH
  } state_t;

endpackage

>>> rtl/clg_div.sv
// clg_div: restoring unsigned divider, one quotient bit per cycle.
// Needs dividend < divisor * 2^QUOT_W. Depends on clg_pkg.
module clg_div
  import clg_pkg::*;
(
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  start,
  input  logic [DIVIDEND_W-1:0] dividend,
  input  logic [DEN_W-1:0]      divisor,
  output logic                  done,
  output logic [QUOT_W-1:0]     quotient
);

  localparam int CNT_W = $clog2(QUOT_W + 1);

  logic [DEN_W-1:0]  rem;
  logic [DEN_W-1:0]  dsr;
  logic [QUOT_W-1:0] shreg;
  logic [CNT_W-1:0]  cnt;
  logic              busy;

  logic [DEN_W:0]    shifted;
  logic [DEN_W:0]    diff;
  logic              fits;
  logic [DEN_W-1:0]  rem_next;

  always_comb begin
    shifted  = {rem, shreg[QUOT_W-1]};
    fits     = shifted >= {1'b0, dsr};
    diff     = shifted - {1'b0, dsr};
    rem_next = fits ? diff[DEN_W-1:0] : shifted[DEN_W-1:0];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      cnt  <= '0;
      done <= 1'b0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy <= 1'b1;
        cnt  <= CNT_W'(QUOT_W);
      end else if (busy) begin
        cnt <= cnt - CNT_W'(1);
        if (cnt == CNT_W'(1)) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      rem   <= DEN_W'(dividend[DIVIDEND_W-1:QUOT_W]);
      shreg <= dividend[QUOT_W-1:0];
      dsr   <= divisor;
    end else if (busy) begin
      rem   <= rem_next;
      shreg <= {shreg[QUOT_W-2:0], fits};
    end
  end

  assign quotient = shreg;

endmodule

>>> rtl/compressor_limiter_gate_unit.sv
// compressor_limiter_gate_unit: peak-envelope compressor, limiter and noise gate
// a request runs through the sequencer states from acceptance to result valid;
// the compressor and the limiter may each add a division
// throughput: a new request is taken only once the sequencer is back in idle;
// set by one shared 27x24 multiplier over up to ten products and a divider used up to twice
// reset: envelopes, held peak, sequencer and output valid cleared; registers to defaults
module compressor_limiter_gate_unit
  import clg_pkg::*;
#(
  parameter int CHANNELS = 2
) (
  input  logic                clk,
  input  logic                rst,
  // input request channel
  input  logic                in_valid,
  output logic                in_stall,
  input  logic [SAMPLE_W-1:0] sample_a,
  input  logic [SAMPLE_W-1:0] sample_b,
  // result channel
  output logic                out_valid,
  input  logic                out_stall,
  output logic [SAMPLE_W-1:0] out_a,
  output logic [SAMPLE_W-1:0] out_b,
  // configuration write port
  input  logic                cfg_we,
  input  logic [IDX_W-1:0]    cfg_index,
  input  logic [CFG_W-1:0]    cfg_data
);

  // only the first two channels exist on the ports
  localparam logic USE_B = (CHANNELS >= 2);

  // ---------------------------------------------------------------------------
  // helpers
  // ---------------------------------------------------------------------------
  // coefficients above 1.0 act as exactly 1.0
  function automatic logic [COEF_W-1:0] clamp_one(input logic [COEF_W-1:0] c);
    return (c > ONE_Q23) ? ONE_Q23 : c;
  endfunction

  // restore sign and saturate a scaled magnitude to 24 bits
  function automatic logic [SAMPLE_W-1:0] sat_out(input logic neg,
                                                  input logic [26:0] p);
    logic [SAMPLE_W-1:0] r;
    if (neg) begin
      r = (p > 27'(ONE_Q23)) ? MIN_NEG : (~p[SAMPLE_W-1:0] + 24'd1);
    end else begin
      r = (p > 27'(MAX_POS)) ? MAX_POS : p[SAMPLE_W-1:0];
    end
    return r;
  endfunction

  // ---------------------------------------------------------------------------
  // configuration registers
  // ---------------------------------------------------------------------------
  logic [THR_W-1:0]  comp_threshold;
  logic [COEF_W-1:0] ratio_coeff;
  logic [COEF_W-1:0] makeup_gain;
  logic [COEF_W-1:0] attack_coeff;
  logic [COEF_W-1:0] release_coeff;
  logic [GTHR_W-1:0] gate_threshold;
  logic [COEF_W-1:0] gate_attack_coeff;
  logic [COEF_W-1:0] gate_release_coeff;

  always_ff @(posedge clk) begin
    if (rst) begin
      comp_threshold     <= 27'd1052829;
      ratio_coeff        <= 24'd1761608;
      makeup_gain        <= 24'd2092143;
      attack_coeff       <= 24'd17392;
      release_coeff      <= 24'd8386861;
      gate_threshold     <= 25'h1800000;   // -1.0, gate always open
      gate_attack_coeff  <= 24'd832700;
      gate_release_coeff <= 24'd8379879;
    end else if (cfg_we) begin
      case (cfg_index)
        REG_COMP_THRESHOLD:     comp_threshold     <= cfg_data[THR_W-1:0];
        REG_RATIO_COEFF:        ratio_coeff        <= cfg_data[COEF_W-1:0];
        REG_MAKEUP_GAIN:        makeup_gain        <= cfg_data[COEF_W-1:0];
        REG_ATTACK_COEFF:       attack_coeff       <= cfg_data[COEF_W-1:0];
        REG_RELEASE_COEFF:      release_coeff      <= cfg_data[COEF_W-1:0];
        REG_GATE_THRESHOLD:     gate_threshold     <= cfg_data[GTHR_W-1:0];
        REG_GATE_ATTACK_COEFF:  gate_attack_coeff  <= cfg_data[COEF_W-1:0];
        REG_GATE_RELEASE_COEFF: gate_release_coeff <= cfg_data[COEF_W-1:0];
        default: ;
      endcase
    end
  end

  logic [COEF_W-1:0] at_c, re_c, ga_c, gr_c;
  assign at_c = clamp_one(attack_coeff);
  assign re_c = clamp_one(release_coeff);
  assign ga_c = clamp_one(gate_attack_coeff);
  assign gr_c = clamp_one(gate_release_coeff);

  // ---------------------------------------------------------------------------
  // datapath registers
  // ---------------------------------------------------------------------------
  state_t state, state_next;

  logic [COEF_W-1:0]   level_envelope;  // Q0.23, at most 1.0
  logic [COEF_W-1:0]   held_peak;
  logic [COEF_W-1:0]   gate_envelope;

  logic                sign_a, sign_b;
  logic [SAMPLE_W-1:0] mag_a, mag_b;    // magnitudes, -1.0 maps to 1.0
  logic [SAMPLE_W-1:0] peak;
  logic [QUOT_W-1:0]   gain;            // Q4.20
  logic [DEN_W-1:0]    den;
  logic                gate_open;
  logic [SAMPLE_W-1:0] res_a;

  // shared multiplier, product registered every cycle
  logic [MUL_A_W-1:0]  mul_a;
  logic [MUL_B_W-1:0]  mul_b;
  logic [PROD_W-1:0]   prod;

  always_ff @(posedge clk) begin
    prod <= PROD_W'(mul_a) * PROD_W'(mul_b);
  end

  // shared divider
  logic                  div_start;
  logic [DIVIDEND_W-1:0] div_dividend;
  logic [DEN_W-1:0]      div_divisor;
  logic                  div_done;
  logic [QUOT_W-1:0]     div_quot;

  clg_div u_div (
    .clk      (clk),
    .rst      (rst),
    .start    (div_start),
    .dividend (div_dividend),
    .divisor  (div_divisor),
    .done     (div_done),
    .quotient (div_quot)
  );

  // derived compares on current register values; out_free also looks at out_stall
  logic [SAMPLE_W-1:0] peak_now;
  logic                le_above_th;
  logic [THR_W-1:0]    le_minus_th;
  logic                gate_open_now;
  logic                out_free;

  always_comb begin
    peak_now      = (USE_B && (mag_b > mag_a)) ? mag_b : mag_a;
    le_above_th   = {3'b000, level_envelope} > comp_threshold;
    le_minus_th   = {3'b000, level_envelope} - comp_threshold;
    gate_open_now = $signed({2'b00, level_envelope}) >
                    $signed({gate_threshold[GTHR_W-1], gate_threshold});
    out_free      = !out_valid || !out_stall;
  end

  // ---------------------------------------------------------------------------
  // sequencer: state register
  // ---------------------------------------------------------------------------
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // next state, multiplier operands and divider requests
  always_comb begin
    state_next   = state;
    mul_a        = '0;
    mul_b        = '0;
    div_start    = 1'b0;
    div_dividend = prod[DIVIDEND_W-1:0];
    div_divisor  = den;
    case (state)
      S_IDLE: begin
        if (in_valid) state_next = S_PEAK;
      end
      S_PEAK: begin
        // release step of the level envelope
        mul_a      = {3'b000, level_envelope};
        mul_b      = re_c;
        state_next = S_LE_REL;
      end
      S_LE_REL: begin
        mul_a      = {3'b000, held_peak};
        mul_b      = re_c;
        state_next = S_HP_REL;
      end
      S_HP_REL: begin
        // level_envelope already holds the released value here
        if (peak > level_envelope) begin
          mul_a      = {3'b000, at_c};
          mul_b      = peak - level_envelope;
          state_next = S_ATK;
        end else begin
          state_next = S_COMP;
        end
      end
      S_ATK: begin
        state_next = S_COMP;
      end
      S_COMP: begin
        if (le_above_th) begin
          mul_a      = {3'b000, ratio_coeff};
          mul_b      = le_minus_th[COEF_W-1:0];
          state_next = S_COMP_DEN;
        end else begin
          state_next = S_LIM;
        end
      end
      S_COMP_DEN: begin
        // numerator makeup * threshold
        mul_a      = comp_threshold;
        mul_b      = makeup_gain;
        state_next = S_COMP_DIV_START;
      end
      S_COMP_DIV_START: begin
        // zero divisor keeps the makeup gain
        if (den != '0) begin
          div_start  = 1'b1;
          state_next = S_DIV_COMP;
        end else begin
          state_next = S_LIM;
        end
      end
      S_DIV_COMP: begin
        if (div_done) state_next = S_LIM;
      end
      S_LIM: begin
        mul_a      = {3'b000, gain};
        mul_b      = held_peak;
        state_next = S_LIM_CHK;
      end
      S_LIM_CHK: begin
        // gain times held peak above 1.0: gain becomes 1 / held peak
        if ((held_peak != '0) && (prod > LIMIT_ONE)) begin
          div_start    = 1'b1;
          div_dividend = LIMIT_ONE;
          div_divisor  = {4'b0000, held_peak};
          state_next   = S_DIV_LIM;
        end else begin
          state_next = S_GATE;
        end
      end
      S_DIV_LIM: begin
        if (div_done) state_next = S_GATE;
      end
      S_GATE: begin
        if (gate_open_now) begin
          mul_a = {3'b000, ga_c};
          mul_b = ONE_Q23 - gate_envelope;
        end else begin
          mul_a = {3'b000, gate_envelope};
          mul_b = gr_c;
        end
        state_next = S_GATE_UPD;
      end
      S_GATE_UPD: begin
        state_next = S_FIN;
      end
      S_FIN: begin
        mul_a      = {3'b000, gain};
        mul_b      = gate_envelope;
        state_next = S_FIN_GAIN;
      end
      S_FIN_GAIN: begin
        state_next = S_OUT_A;
      end
      S_OUT_A: begin
        mul_a      = {3'b000, mag_a};
        mul_b      = gain;
        state_next = S_OUT_B;
      end
      S_OUT_B: begin
        mul_a      = {3'b000, mag_b};
        mul_b      = gain;
        state_next = S_PUSH;
      end
      S_PUSH: begin
        // keep channel b product alive while the output register is busy
        mul_a = {3'b000, mag_b};
        mul_b = gain;
        if (out_free) state_next = S_IDLE;
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  // no request is taken while reset is held
  assign in_stall = rst || (state != S_IDLE);

  // ---------------------------------------------------------------------------
  // envelope state, cleared by reset
  // ---------------------------------------------------------------------------
  always_ff @(posedge clk) begin
    if (rst) begin
      level_envelope <= '0;
      held_peak      <= '0;
      gate_envelope  <= '0;
    end else begin
      case (state)
        S_LE_REL:   level_envelope <= prod[46:23];
        S_HP_REL:   held_peak      <= prod[46:23];
        S_ATK: begin
          level_envelope <= level_envelope + prod[46:23];
          held_peak      <= peak;
        end
        S_GATE_UPD: begin
          gate_envelope <= gate_open ? (gate_envelope + prod[46:23]) : prod[46:23];
        end
        default: ;
      endcase
    end
  end

  // ---------------------------------------------------------------------------
  // per-request payload registers
  // ---------------------------------------------------------------------------
  always_ff @(posedge clk) begin
    case (state)
      S_IDLE: begin
        sign_a <= sample_a[SAMPLE_W-1];
        sign_b <= sample_b[SAMPLE_W-1];
        mag_a  <= sample_a[SAMPLE_W-1] ? (~sample_a + 24'd1) : sample_a;
        mag_b  <= sample_b[SAMPLE_W-1] ? (~sample_b + 24'd1) : sample_b;
      end
      S_PEAK:      peak <= peak_now;
      S_COMP:      gain <= makeup_gain;
      S_COMP_DEN:  den  <= {1'b0, comp_threshold} + DEN_W'(prod[46:22]);
      S_DIV_COMP:  if (div_done) gain <= div_quot;
      S_DIV_LIM:   if (div_done) gain <= div_quot;
      S_GATE:      gate_open <= gate_open_now;
      S_FIN_GAIN:  gain <= prod[46:23];
      S_OUT_B:     res_a <= sat_out(sign_a, prod[46:20]);
      default: ;
    endcase
  end

  // ---------------------------------------------------------------------------
  // output register
  // ---------------------------------------------------------------------------
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if ((state == S_PUSH) && out_free) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if ((state == S_PUSH) && out_free) begin
      out_a <= res_a;
      out_b <= USE_B ? sat_out(sign_b, prod[46:20]) : '0;
    end
  end

  // ---------------------------------------------------------------------------
  // checks
  // ---------------------------------------------------------------------------
  a_level_le_one: assert property (@(posedge clk) disable iff (rst)
    level_envelope <= ONE_Q23)
    else $error("level envelope above 1.0");

  a_gate_le_one: assert property (@(posedge clk) disable iff (rst)
    gate_envelope <= ONE_Q23)
    else $error("gate envelope above 1.0");

  a_hold_le_one: assert property (@(posedge clk) disable iff (rst)
    held_peak <= ONE_Q23)
    else $error("held peak above 1.0");

  a_accept_starts: assert property (@(posedge clk) disable iff (rst)
    (in_valid && !in_stall) |=> (state == S_PEAK))
    else $error("accepted request did not start the sequence");

  a_div_done_waited: assert property (@(posedge clk) disable iff (rst)
    div_done |-> ((state == S_DIV_COMP) || (state == S_DIV_LIM)))
    else $error("divider finished outside a wait state");

endmodule
